[sv/prc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package prc_pkg;

    // Default grid coordinate width
    localparam int COORD_BITS_DEF = 16;

    // Result queue depth; one item may push two beats
    localparam int OUT_DEPTH = 4;

    // Push request from the point stage into the result queue
    typedef struct packed {
        logic first;   // corner beat, last = 0
        logic second;  // final point of the path, last = 1
    } prc_push_t;

endpackage

`default_nettype wire

[sv/prc_collinear.sv]
`timescale 1ns / 1ps
`default_nettype none

module prc_collinear #(
    parameter int COORD_BITS = prc_pkg::COORD_BITS_DEF
) (
    input  wire logic [COORD_BITS-1:0] anchor_x,
    input  wire logic [COORD_BITS-1:0] anchor_y,
    input  wire logic [COORD_BITS-1:0] pending_x,
    input  wire logic [COORD_BITS-1:0] pending_y,
    input  wire logic [COORD_BITS-1:0] point_x,
    input  wire logic [COORD_BITS-1:0] point_y,
    output logic                       collinear
);
    import prc_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] d1x, d1y, d2x, d2y;
    logic signed [PW-1:0] p1, p2;

    // Direction vectors from the anchor, one sign bit wider than a coordinate
    assign d1x = $signed({1'b0, pending_x}) - $signed({1'b0, anchor_x});
    assign d1y = $signed({1'b0, pending_y}) - $signed({1'b0, anchor_y});
    assign d2x = $signed({1'b0, point_x}) - $signed({1'b0, anchor_x});
    assign d2y = $signed({1'b0, point_y}) - $signed({1'b0, anchor_y});

    // Exact cross product test: d1 x d2 == 0
    assign p1 = PW'(d1x) * PW'(d2y);
    assign p2 = PW'(d1y) * PW'(d2x);

    assign collinear = (p1 == p2);

endmodule

`default_nettype wire

[sv/prc_out_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module prc_out_fifo #(
    parameter int COORD_BITS = prc_pkg::COORD_BITS_DEF,
    parameter int DEPTH      = prc_pkg::OUT_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire prc_pkg::prc_push_t    push,
    input  wire logic [COORD_BITS-1:0] first_x,
    input  wire logic [COORD_BITS-1:0] first_y,
    input  wire logic [COORD_BITS-1:0] second_x,
    input  wire logic [COORD_BITS-1:0] second_y,
    output logic                       room,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [COORD_BITS-1:0]      out_x,
    output logic [COORD_BITS-1:0]      out_y,
    output logic                       out_last
);
    import prc_pkg::*;

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    logic [COORD_BITS-1:0] mem_x [DEPTH];
    logic [COORD_BITS-1:0] mem_y [DEPTH];
    logic                  mem_last [DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next, second_ptr;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [CNT_BITS-1:0] push_cnt;
    logic                pop;

    assign pop        = out_valid && out_ready;
    assign push_cnt   = CNT_BITS'(push.first) + CNT_BITS'(push.second);
    assign second_ptr = wr_ptr_reg + PTR_BITS'(push.first);

    assign wr_ptr_next = wr_ptr_reg + push_cnt[PTR_BITS-1:0];
    assign rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
    assign count_next  = count_reg + push_cnt - CNT_BITS'(pop);

    // Room for a full two-beat push
    assign room      = (count_reg <= CNT_BITS'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_x     = mem_x[rd_ptr_reg];
    assign out_y     = mem_y[rd_ptr_reg];
    assign out_last  = mem_last[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.first) begin
            mem_x[wr_ptr_reg]    <= first_x;
            mem_y[wr_ptr_reg]    <= first_y;
            mem_last[wr_ptr_reg] <= 1'b0;
        end
        if (push.second) begin
            mem_x[second_ptr]    <= second_x;
            mem_y[second_ptr]    <= second_y;
            mem_last[second_ptr] <= 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.first || push.second) |-> room)
        else $error("push without room");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push.first && !push.second) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("count did not drop on pop");

endmodule

`default_nettype wire

[sv/path_collinear_point_reducer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | ports                                  | beat
// --------+----------------------------------------+--------------------------------
// input   | s_valid s_ready s_point_x/_y s_path_end | one path point
// result  | m_valid m_ready m_out_x/_y m_out_last   | one kept corner, last on final
//
// A point is captured in the input register, then it is tested against
// the anchor/pending pair (two cross-product multiplies and a compare)
// and zero, one or two result beats go into a 4-entry queue.
// With m_ready high, sustained rate is one point per cycle; a point that ends
// a path with a corner makes two beats, which drain at one per cycle through
// the queue. The point stage waits while the queue has fewer than two free
// entries. aresetn is synchronous, active low; it empties the input register
// and queue and starts a new path.
module path_collinear_point_reducer #(
    parameter int COORD_BITS = prc_pkg::COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [COORD_BITS-1:0] s_point_x,
    input  wire logic [COORD_BITS-1:0] s_point_y,
    input  wire logic                  s_path_end,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [COORD_BITS-1:0]      m_out_x,
    output logic [COORD_BITS-1:0]      m_out_y,
    output logic                       m_out_last
);
    import prc_pkg::*;

    // Points seen on the current path, saturating at a straight run
    typedef enum logic [1:0] {
        SEEN_NONE,
        SEEN_ONE,
        SEEN_RUN
    } seen_t;

    seen_t seen_reg, seen_next;

    // Input register
    logic                  in_valid_reg;
    logic [COORD_BITS-1:0] in_x_reg, in_y_reg;
    logic                  in_end_reg;

    // Last emitted corner and end of the current straight run
    logic [COORD_BITS-1:0] anchor_x_reg, anchor_y_reg, anchor_x_next, anchor_y_next;
    logic [COORD_BITS-1:0] pending_x_reg, pending_y_reg, pending_x_next, pending_y_next;

    prc_push_t             push;
    logic [COORD_BITS-1:0] first_x, first_y;
    logic                  room;
    logic                  fire;
    logic                  collinear;

    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_x_reg   <= s_point_x;
            in_y_reg   <= s_point_y;
            in_end_reg <= s_path_end;
        end
    end

    prc_collinear #(
        .COORD_BITS(COORD_BITS)
    ) u_collinear (
        .anchor_x (anchor_x_reg),
        .anchor_y (anchor_y_reg),
        .pending_x(pending_x_reg),
        .pending_y(pending_y_reg),
        .point_x  (in_x_reg),
        .point_y  (in_y_reg),
        .collinear(collinear)
    );

    always_comb begin
        seen_next      = seen_reg;
        anchor_x_next  = anchor_x_reg;
        anchor_y_next  = anchor_y_reg;
        pending_x_next = pending_x_reg;
        pending_y_next = pending_y_reg;
        push           = '0;
        first_x        = pending_x_reg;
        first_y        = pending_y_reg;
        if (fire) begin
            unique case (seen_reg)
                SEEN_NONE: begin
                    // First point only becomes the anchor
                    anchor_x_next = in_x_reg;
                    anchor_y_next = in_y_reg;
                    seen_next     = in_end_reg ? SEEN_NONE : SEEN_ONE;
                end
                SEEN_ONE: begin
                    push.first     = 1'b1;
                    first_x        = anchor_x_reg;
                    first_y        = anchor_y_reg;
                    pending_x_next = in_x_reg;
                    pending_y_next = in_y_reg;
                    seen_next      = SEEN_RUN;
                end
                SEEN_RUN: begin
                    if (!collinear) begin
                        // Corner: pending goes out and anchors the next run
                        push.first    = 1'b1;
                        anchor_x_next = pending_x_reg;
                        anchor_y_next = pending_y_reg;
                    end
                    pending_x_next = in_x_reg;
                    pending_y_next = in_y_reg;
                end
                default: begin
                    seen_next = SEEN_NONE;
                end
            endcase
            // Path end flushes the final point (if the path had two or more)
            if (in_end_reg) begin
                seen_next = SEEN_NONE;
                if (seen_reg != SEEN_NONE) begin
                    push.second = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= SEEN_NONE;
        end else begin
            seen_reg <= seen_next;
        end
        anchor_x_reg  <= anchor_x_next;
        anchor_y_reg  <= anchor_y_next;
        pending_x_reg <= pending_x_next;
        pending_y_reg <= pending_y_next;
    end

    prc_out_fifo #(
        .COORD_BITS(COORD_BITS),
        .DEPTH     (OUT_DEPTH)
    ) u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .first_x  (first_x),
        .first_y  (first_y),
        .second_x (in_x_reg),
        .second_y (in_y_reg),
        .room     (room),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_x    (m_out_x),
        .out_y    (m_out_y),
        .out_last (m_out_last)
    );

    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_end_reg) |=> seen_reg == SEEN_NONE)
        else $error("path end did not restart the path");

    a_first_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (seen_reg == SEEN_NONE) |-> (!push.first && !push.second))
        else $error("beat pushed on first point of a path");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !room) |-> !s_ready)
        else $error("input taken while point stage stalled");

endmodule

`default_nettype wire

[dv/path_collinear_point_reducer_chk.sv]
`timescale 1ns / 1ps

// Watches both channels, predicts the kept corners of every path and
// compares each result beat with the oldest prediction.
module path_collinear_point_reducer_chk (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    input  wire logic                               s_ready,
    input  wire logic [prc_pkg::COORD_BITS_DEF-1:0] s_point_x,
    input  wire logic [prc_pkg::COORD_BITS_DEF-1:0] s_point_y,
    input  wire logic                               s_path_end,
    input  wire logic                               m_valid,
    input  wire logic                               m_ready,
    input  wire logic [prc_pkg::COORD_BITS_DEF-1:0] m_out_x,
    input  wire logic [prc_pkg::COORD_BITS_DEF-1:0] m_out_y,
    input  wire logic                               m_out_last,
    output int                                      fail_count,
    output int                                      corners_due
);
    localparam int CW = prc_pkg::COORD_BITS_DEF;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } corner_t;

    corner_t       corner_q[$];
    logic [CW-1:0] anc_x, anc_y;   // last corner sent out
    logic [CW-1:0] run_x, run_y;   // far end of the current straight run
    logic [1:0]    pts_seen;

    initial begin
        fail_count  = 0;
        corners_due = 0;
    end

    // exact cross product, measured from the anchor
    function automatic bit on_line(input logic [CW-1:0] nx, input logic [CW-1:0] ny);
        longint d1x, d1y, d2x, d2y;
        d1x = longint'(run_x) - longint'(anc_x);
        d1y = longint'(run_y) - longint'(anc_y);
        d2x = longint'(nx) - longint'(anc_x);
        d2y = longint'(ny) - longint'(anc_y);
        return (d1x * d2y) == (d1y * d2x);
    endfunction

    task automatic push_corner(input logic [CW-1:0] x, input logic [CW-1:0] y,
                               input logic last);
        corner_t c;
        c.x    = x;
        c.y    = y;
        c.last = last;
        corner_q.insert(corner_q.size(), c);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        corner_t want;
        if (!aresetn) begin
            corner_q.delete();
            anc_x    = '0;
            anc_y    = '0;
            run_x    = '0;
            run_y    = '0;
            pts_seen = 2'd0;
        end else begin
            // compare first: a beat leaving now cannot come from a point entering now
            if (m_valid && m_ready) begin
                if (corner_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual x=%h y=%h last=%b",
                             $time, m_out_x, m_out_y, m_out_last);
                    fail_count++;
                end else begin
                    want = corner_q.pop_front();
                    check_field("out_x", want.x, m_out_x);
                    check_field("out_y", want.y, m_out_y);
                    check_field("out_last", want.last, m_out_last);
                end
            end
            if (s_valid && s_ready) begin
                if (pts_seen == 2'd0) begin
                    anc_x    = s_point_x;
                    anc_y    = s_point_y;
                    pts_seen = s_path_end ? 2'd0 : 2'd1;
                end else begin
                    if (pts_seen == 2'd1) begin
                        push_corner(anc_x, anc_y, 1'b0);
                        pts_seen = 2'd2;
                    end else if (!on_line(s_point_x, s_point_y)) begin
                        push_corner(run_x, run_y, 1'b0);
                        anc_x = run_x;
                        anc_y = run_y;
                    end
                    run_x = s_point_x;
                    run_y = s_point_y;
                    if (s_path_end) begin
                        push_corner(run_x, run_y, 1'b1);
                        pts_seen = 2'd0;
                    end
                end
            end
        end
        corners_due <= corner_q.size();
    end

endmodule

[dv/path_collinear_point_reducer_tb.sv]
`timescale 1ns / 1ps

// Top of the bench: clock, reset, point stimulus, result-side back-pressure
// and the verdict. Prediction and comparison live in the checker.
module path_collinear_point_reducer_tb;

    localparam int CW          = prc_pkg::COORD_BITS_DEF;
    localparam int ITEM_TARGET = 820;     // directed + ~800 random points
    localparam int HOLD_CYCLES = 200;     // long receiver hold-off
    localparam int CYCLE_LIMIT = 400000;  // watchdog on the whole run
    localparam int DRAIN_TAIL  = 20;      // idle time after the final drain

    logic          aclk       = 1'b0;
    logic          aresetn    = 1'b0;
    logic          s_valid    = 1'b0;
    logic          s_ready;
    logic [CW-1:0] s_point_x  = '0;
    logic [CW-1:0] s_point_y  = '0;
    logic          s_path_end = 1'b0;
    logic          m_valid;
    logic          m_ready    = 1'b0;
    logic [CW-1:0] m_out_x;
    logic [CW-1:0] m_out_y;
    logic          m_out_last;

    int fail_count;
    int corners_due;
    int points_sent  = 0;
    int holds_asked  = 0;
    int cycle_count  = 0;
    bit src_quiet    = 1'b0;   // sender burst mode: no gaps between beats

    always #5 aclk = ~aclk;

    path_collinear_point_reducer uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_point_x  (s_point_x),
        .s_point_y  (s_point_y),
        .s_path_end (s_path_end),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_x    (m_out_x),
        .m_out_y    (m_out_y),
        .m_out_last (m_out_last)
    );

    path_collinear_point_reducer_chk chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .s_path_end  (s_path_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_last  (m_out_last),
        .fail_count  (fail_count),
        .corners_due (corners_due)
    );

    // Gap lengths: mostly back-to-back, some short gaps, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Coordinates with extra weight on the grid edges.
    function automatic logic [CW-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return '1;
        else if (r < 30)
            return CW'($urandom_range(0, 15));
        return CW'($urandom_range(0, 65535));
    endfunction

    // Step vector for a straight run: mostly unit-ish moves, some scaled
    // moves, and some huge ones that push the cross products to full width.
    task automatic pick_dir(output int dx, output int dy);
        int r, k;
        r  = $urandom_range(0, 99);
        dx = int'($urandom_range(0, 6)) - 3;
        dy = int'($urandom_range(0, 6)) - 3;
        if (r >= 90) begin
            dx = int'($urandom_range(0, 65535)) - 32768;
            dy = int'($urandom_range(0, 65535)) - 32768;
        end else if (r >= 70) begin
            k  = $urandom_range(1, 300);
            dx = dx * k;
            dy = dy * k;
        end
    endtask

    // Offer one point and hold it until accepted. Valid is only raised
    // here, never lowered, so back-to-back beats keep it high.
    task automatic send_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
                              input logic fin);
        s_valid    <= 1'b1;
        s_point_x  <= px;
        s_point_y  <= py;
        s_path_end <= fin;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        points_sent++;
    endtask

    task automatic src_idle(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic feed(input logic [CW-1:0] px, input logic [CW-1:0] py, input logic fin);
        send_point(px, py, fin);
        src_idle(src_quiet ? 0 : gap_len());
    endtask

    // Sender stops and waits until every predicted corner has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (corners_due == 0);
    endtask

    // One well-formed path: a walk of straight runs, turns, repeated
    // points and the odd jump to anywhere on the grid.
    task automatic send_path(input int len);
        logic [CW-1:0] cx, cy;
        int dx, dy, r;
        cx = rand_coord();
        cy = rand_coord();
        pick_dir(dx, dy);
        for (int i = 0; i < len; i++) begin
            if (i > 0) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    // repeat the last point
                end else if (r < 55) begin
                    cx = cx + CW'(dx);
                    cy = cy + CW'(dy);
                end else if (r < 85) begin
                    pick_dir(dx, dy);
                    cx = cx + CW'(dx);
                    cy = cy + CW'(dy);
                end else begin
                    cx = rand_coord();
                    cy = rand_coord();
                end
            end
            feed(cx, cy, i == len - 1);
        end
    endtask

    // Result side: random ready with quiet stretches; a requested hold-off
    // drops ready for HOLD_CYCLES, counted here. One ready update per edge.
    initial begin : sink
        int gap;
        int holds_served;
        bit sink_quiet;
        holds_served = 0;
        sink_quiet   = 1'b0;
        @(posedge aclk);
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0)
                sink_quiet = !sink_quiet;
            if (holds_served != holds_asked) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_served++;
            end else begin
                gap = sink_quiet ? 0 : gap_len();
                if (gap == 0) begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[path_collinear_point_reducer] ERROR");
            $finish;
        end
    end

    initial begin : stim
        int  len, r;
        bit  stalled, paused;
        stalled = 1'b0;
        paused  = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // lone points: dropped, no beat
        feed('0, '0, 1'b1);
        feed('1, '1, 1'b1);
        // two-point paths: both points are pushed together
        feed('0, '0, 1'b0);
        feed('1, '1, 1'b1);
        feed(16'hFFFF, 16'h0000, 1'b0);
        feed(16'h0000, 16'hFFFF, 1'b1);
        // repeated points then a straight run; only the ends survive
        feed(16'd5, 16'd5, 1'b0);
        feed(16'd5, 16'd5, 1'b0);
        feed(16'd5, 16'd5, 1'b0);
        feed(16'd9, 16'd9, 1'b0);
        feed(16'd12, 16'd12, 1'b1);
        // L-turn, then a turn to the far grid corner on the last point
        feed(16'd0, 16'd0, 1'b0);
        feed(16'd10, 16'd0, 1'b0);
        feed(16'd20, 16'd0, 1'b0);
        feed(16'd20, 16'd10, 1'b0);
        feed('1, '1, 1'b1);
        // backtrack on the line counts as straight; then a point whose
        // cross products match in size but not in sign is a corner
        feed(16'd100, 16'd100, 1'b0);
        feed(16'd110, 16'd90, 1'b0);
        feed(16'd90, 16'd110, 1'b0);
        feed(16'd110, 16'd110, 1'b1);
        // long diagonal across the whole grid
        feed(16'h0000, 16'h0000, 1'b0);
        feed(16'h8000, 16'h8000, 1'b0);
        feed(16'hFFFF, 16'hFFFF, 1'b1);
        wait_drained();

        while (points_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0)
                src_quiet = !src_quiet;
            if (!stalled && points_sent >= 300) begin
                // receiver holds off while points keep coming: queue fills,
                // s_ready must drop and nothing may be lost
                stalled     = 1'b1;
                holds_asked <= holds_asked + 1;
                src_quiet   = 1'b1;
                send_path(48);
                src_quiet   = 1'b0;
            end else if (!paused && points_sent >= 560) begin
                paused = 1'b1;
                wait_drained();
            end else begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    len = 1;
                else if (r < 12)
                    len = 2;
                else if (r < 80)
                    len = $urandom_range(3, 12);
                else
                    len = $urandom_range(13, 30);
                send_path(len);
            end
        end

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (fail_count == 0)
            $display("[path_collinear_point_reducer] OK");
        else
            $display("[path_collinear_point_reducer] ERROR");
        $finish;
    end

endmodule
